// ----- rtl/core/rhc_pkg.sv -----
`default_nettype none

package rhc_pkg;

    localparam int COMP_W = 8;
    localparam int HUE_W  = 16;

    // 6 * spread must fit
    localparam int DIV_W  = COMP_W + 3;

    // division steps: enough for the hue bits and for the 2*COMP_W bit saturation dividend
    localparam int NSTAGE = (HUE_W > 2 * COMP_W) ? HUE_W : 2 * COMP_W;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] opacity;
    } t_rgba;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [COMP_W-1:0] saturation;
        logic [COMP_W-1:0] brightness;
        logic [COMP_W-1:0] opacity_out;
    } t_hsva;

    // State handed from one divider cell to the next
    typedef struct packed {
        logic              valid;
        logic [DIV_W-1:0]  hue_div;
        logic [DIV_W-1:0]  hue_rem;
        logic [NSTAGE-1:0] hue_q;
        logic [COMP_W-1:0] sat_div;
        logic [COMP_W-1:0] sat_rem;
        logic [NSTAGE-1:0] sat_num;
        logic [COMP_W-1:0] sat_q;
        logic [COMP_W-1:0] brightness;
        logic [COMP_W-1:0] opacity;
    } t_cell;

endpackage

`default_nettype wire

// ----- rtl/core/rgb_to_hsv_converter_top.sv -----
// Channel  Valid     Ready     Payload
// input    i_valid   o_ready   i_pixel (t_rgba: red, green, blue, opacity)
// output   o_valid   i_ready   o_pixel (t_hsva: hue, saturation, brightness, opacity_out)
//
// One pixel per clock while the output is not stalled: a min/max stage, then a
// row of NSTAGE divider cells, each resolving one hue and one saturation quotient bit.
// The whole row advances together; a stall on the output holds every cell.
// Synchronous active-low reset clears the valid bits only.
`default_nettype none

module rgb_to_hsv_converter_top
    import rhc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_rgba i_pixel,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_hsva      o_pixel
);

    t_cell w_chain [0:NSTAGE];
    logic  w_en;

    assign w_en    = i_ready || !w_chain[NSTAGE].valid;
    assign o_ready = w_en;

    rhc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_pixel (i_pixel),
        .o_cell  (w_chain[0])
    );

    for (genvar g = 0; g < NSTAGE; g++) begin : g_cell
        rhc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    assign o_valid             = w_chain[NSTAGE].valid;
    assign o_pixel.hue         = w_chain[NSTAGE].hue_q[NSTAGE-1 -: HUE_W];
    assign o_pixel.saturation  = w_chain[NSTAGE].sat_q;
    assign o_pixel.brightness  = w_chain[NSTAGE].brightness;
    assign o_pixel.opacity_out = w_chain[NSTAGE].opacity;

    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel.brightness == '0) |->
            (o_pixel.saturation == '0 && o_pixel.hue == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel.saturation == '0) |-> (o_pixel.hue == '0))
        else $error("grey pixel with nonzero hue");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty output stage");

endmodule

`default_nettype wire

// ----- rtl/core/rhc_prep.sv -----
`default_nettype none

module rhc_prep
    import rhc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_rgba i_pixel,
    output t_cell      o_cell
);

    logic [COMP_W-1:0]   w_hi;
    logic [COMP_W-1:0]   w_lo;
    logic [COMP_W-1:0]   w_d;
    logic [DIV_W-1:0]    w_d6;
    logic [DIV_W-1:0]    w_numer;
    logic [2*COMP_W-1:0] w_sat_num;
    t_cell               n_cell;
    t_cell               r_cell;

    always_comb begin
        w_hi = i_pixel.red;
        w_lo = i_pixel.red;
        if (i_pixel.green > w_hi) w_hi = i_pixel.green;
        if (i_pixel.blue  > w_hi) w_hi = i_pixel.blue;
        if (i_pixel.green < w_lo) w_lo = i_pixel.green;
        if (i_pixel.blue  < w_lo) w_lo = i_pixel.blue;
        w_d  = w_hi - w_lo;
        w_d6 = (DIV_W'(w_d) << 2) + (DIV_W'(w_d) << 1);

        // sector numerator, below 6*spread whenever the spread is nonzero
        if (w_hi == i_pixel.red) begin
            if (i_pixel.green >= i_pixel.blue) begin
                w_numer = DIV_W'(i_pixel.green) - DIV_W'(i_pixel.blue);
            end else begin
                w_numer = w_d6 - (DIV_W'(i_pixel.blue) - DIV_W'(i_pixel.green));
            end
        end else if (w_hi == i_pixel.green) begin
            w_numer = DIV_W'(i_pixel.blue) + (DIV_W'(w_d) << 1) - DIV_W'(i_pixel.red);
        end else begin
            w_numer = DIV_W'(i_pixel.red) + (DIV_W'(w_d) << 2) - DIV_W'(i_pixel.green);
        end

        // spread * full scale
        w_sat_num = ({w_d, {COMP_W{1'b0}}}) - (2*COMP_W)'(w_d);

        n_cell            = '0;
        n_cell.valid      = i_valid;
        n_cell.hue_rem    = w_numer;
        n_cell.sat_num    = NSTAGE'(w_sat_num);
        n_cell.brightness = w_hi;
        n_cell.opacity    = i_pixel.opacity;
        // grey or black: zero numerator over all-ones divisor yields zero
        n_cell.hue_div    = (w_d == '0) ? '1 : w_d6;
        n_cell.sat_div    = (w_hi == '0) ? '1 : w_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.hue_div    <= n_cell.hue_div;
            r_cell.hue_rem    <= n_cell.hue_rem;
            r_cell.hue_q      <= n_cell.hue_q;
            r_cell.sat_div    <= n_cell.sat_div;
            r_cell.sat_rem    <= n_cell.sat_rem;
            r_cell.sat_num    <= n_cell.sat_num;
            r_cell.sat_q      <= n_cell.sat_q;
            r_cell.brightness <= n_cell.brightness;
            r_cell.opacity    <= n_cell.opacity;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

// ----- rtl/core/rhc_cell.sv -----
`default_nettype none

module rhc_cell
    import rhc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_cell i_cell,
    output t_cell      o_cell
);

    logic [DIV_W:0]  w_ht;
    logic [DIV_W:0]  w_hd;
    logic [DIV_W:0]  w_hsub;
    logic [COMP_W:0] w_st;
    logic [COMP_W:0] w_sd;
    logic [COMP_W:0] w_ssub;
    t_cell           n_cell;
    t_cell           r_cell;

    // one restoring step for hue and one for saturation
    always_comb begin
        w_ht   = {i_cell.hue_rem, 1'b0};
        w_hd   = {1'b0, i_cell.hue_div};
        w_hsub = w_ht - w_hd;
        w_st   = {i_cell.sat_rem, i_cell.sat_num[NSTAGE-1]};
        w_sd   = {1'b0, i_cell.sat_div};
        w_ssub = w_st - w_sd;

        n_cell         = i_cell;
        n_cell.sat_num = {i_cell.sat_num[NSTAGE-2:0], 1'b0};
        if (w_ht >= w_hd) begin
            n_cell.hue_rem = w_hsub[DIV_W-1:0];
            n_cell.hue_q   = {i_cell.hue_q[NSTAGE-2:0], 1'b1};
        end else begin
            n_cell.hue_rem = w_ht[DIV_W-1:0];
            n_cell.hue_q   = {i_cell.hue_q[NSTAGE-2:0], 1'b0};
        end
        if (w_st >= w_sd) begin
            n_cell.sat_rem = w_ssub[COMP_W-1:0];
            n_cell.sat_q   = {i_cell.sat_q[COMP_W-2:0], 1'b1};
        end else begin
            n_cell.sat_rem = w_st[COMP_W-1:0];
            n_cell.sat_q   = {i_cell.sat_q[COMP_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.hue_div    <= n_cell.hue_div;
            r_cell.hue_rem    <= n_cell.hue_rem;
            r_cell.hue_q      <= n_cell.hue_q;
            r_cell.sat_div    <= n_cell.sat_div;
            r_cell.sat_rem    <= n_cell.sat_rem;
            r_cell.sat_num    <= n_cell.sat_num;
            r_cell.sat_q      <= n_cell.sat_q;
            r_cell.brightness <= n_cell.brightness;
            r_cell.opacity    <= n_cell.opacity;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire
